>>> design/sorted_id_list_intersect_defines.svh
// ----------------------------------------------------------------------------
// sorted_id_list_intersect_defines
// Assertion macros shared by the sorted id list intersection block.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_LIST_INTERSECT_DEFINES_SVH
`define SORTED_ID_LIST_INTERSECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SIDLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SIDLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sidli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidli_pkg
// Types and constants of the sorted id list intersection block.
// ----------------------------------------------------------------------------
package sidli_pkg;

    localparam int LIST_DEPTH_DEF = 1024;
    localparam int VALUE_W        = 32;
    localparam int TOTAL_W        = 11;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_PROBE  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

>>> design/sidli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidli_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sidli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sorted_id_list_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_list_intersect
// Intersects two ascending id lists: loads fill the store, probes scan it,
// finish reports the match count and overflow flag and clears the job.
//
//   Channel | Dir | Group          | Contents
//   s_*     | in  | tvalid/tready  | tuser = req_type, tdata = element_value
//   m_*     | out | tvalid/tready  | tuser = result_kind, tdata = value/total/ovf
//
// A probe compares stored ids one at a time through the single store read
// port. Pointer advance over a job is bounded by the stored count.
// Reset clears the job registers at once; the store needs no clearing pass.
// A result waiting on a stalled output blocks new input.
// ----------------------------------------------------------------------------
module sorted_id_list_intersect
    import sidli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] common_value, [42:32] match_total,
                                   // [43] store_overflow, [47:44] zero
    output logic        m_tuser    // [0] result_kind
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    state_t state_reg, state_next;

    logic [CW-1:0]      stored_reg,  stored_next;
    logic [CW-1:0]      scan_reg,    scan_next;
    logic               any_reg,     any_next;
    logic [VALUE_W-1:0] last_reg,    last_next;
    logic [TOTAL_W-1:0] emitted_reg, emitted_next;
    logic               ovf_reg,     ovf_next;
    logic [VALUE_W-1:0] probe_reg,   probe_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg,  m_kind_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;
    logic               m_ovf_reg,   m_ovf_next;

    logic               ram_we;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    logic               s_fire;
    logic               out_free;
    logic               scan_live;
    logic [CW-1:0]      scan_inc;
    logic               less_c;
    logic               equal_c;
    logic               dup_c;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign scan_live = scan_reg < stored_reg;
    assign scan_inc  = scan_reg + 1'b1;
    assign less_c    = ram_rd_data < probe_reg;
    assign equal_c   = ram_rd_data == probe_reg;
    assign dup_c     = any_reg && (last_reg == probe_reg);
    assign ram_we    = s_fire && (s_tuser == REQ_LOAD) && (stored_reg < DEPTH_C);

    sidli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (stored_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == REQ_PROBE) && scan_live)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (less_c)
                begin
                    state_next = (scan_inc < stored_reg) ? ST_SCAN : ST_IDLE;
                end
                else if (equal_c && !dup_c && !out_free)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        stored_next  = stored_reg;
        scan_next    = scan_reg;
        any_next     = any_reg;
        last_next    = last_reg;
        emitted_next = emitted_reg;
        ovf_next     = ovf_reg;
        probe_next   = probe_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = scan_reg[AW-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_value_next = m_value_reg;
        m_total_next = m_total_reg;
        m_ovf_next   = m_ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        REQ_LOAD:
                        begin
                            if (stored_reg < DEPTH_C)
                            begin
                                stored_next = stored_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        REQ_PROBE:
                        begin
                            probe_next = s_tdata;
                            ram_rd_en  = scan_live;
                        end
                        REQ_FINISH:
                        begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_DONE;
                            m_value_next = '0;
                            m_total_next = emitted_reg;
                            m_ovf_next   = ovf_reg;
                            stored_next  = '0;
                            scan_next    = '0;
                            any_next     = 1'b0;
                            last_next    = '0;
                            emitted_next = '0;
                            ovf_next     = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (less_c)
                begin
                    scan_next   = scan_inc;
                    ram_rd_addr = scan_inc[AW-1:0];
                    ram_rd_en   = scan_inc < stored_reg;
                end
                else if (equal_c && !dup_c && out_free)
                begin
                    any_next     = 1'b1;
                    last_next    = probe_reg;
                    emitted_next = emitted_reg + 1'b1;
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_MATCH;
                    m_value_next = probe_reg;
                    m_total_next = emitted_reg + 1'b1;
                    m_ovf_next   = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            stored_reg  <= '0;
            scan_reg    <= '0;
            any_reg     <= 1'b0;
            last_reg    <= '0;
            emitted_reg <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stored_reg  <= stored_next;
            scan_reg    <= scan_next;
            any_reg     <= any_next;
            last_reg    <= last_next;
            emitted_reg <= emitted_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg   <= probe_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_total_reg <= m_total_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {4'b0000, m_ovf_reg, m_total_reg, m_value_reg};

`include "sorted_id_list_intersect_defines.svh"

    `SIDLI_ASSERT_NOW(a_scan_in_range, 1'b1, scan_reg <= stored_reg,
        "scan pointer past stored count")
    `SIDLI_ASSERT_NOW(a_store_bound, 1'b1, stored_reg <= DEPTH_C,
        "stored count above depth")
    `SIDLI_ASSERT_NOW(a_no_accept_in_scan, state_reg == ST_SCAN, !s_tready,
        "input taken while scanning")
    `SIDLI_ASSERT_NOW(a_done_zero_value, m_valid_reg && (m_kind_reg == KIND_DONE),
        m_value_reg == '0, "done transfer with nonzero value")
    `SIDLI_ASSERT_NEXT(a_finish_clears, s_fire && (s_tuser == REQ_FINISH),
        (stored_reg == '0) && (emitted_reg == '0) && !ovf_reg,
        "finish did not clear the job")

endmodule
